// File: design/sobs_pkg.sv
`timescale 1ns / 1ps
// sobs_pkg: opcodes, status codes and sequencer states of the set of bounded stacks
// no dependencies

package sobs_pkg;

   // fixed field widths of the item channels
   localparam int VALUE_W = 32;
   localparam int POS_W   = 4;

   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_POP_AT = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_PUSHED = 2'd0,
      ST_POPPED = 2'd1,
      ST_ERROR  = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOK,
      S_READ
   } state_type;

endpackage

// File: design/sobs_if.sv
`timescale 1ns / 1ps
// sobs_req_if and sobs_rsp_if: valid/ready item channels of the set of bounded stacks
// no dependencies

interface sobs_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic signed [31:0] push_value;
   logic [3:0]         substack_position;

   modport source (output valid, opcode, push_value, substack_position, input ready);
   modport sink   (input valid, opcode, push_value, substack_position, output ready);
endinterface

interface sobs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] popped_value;
   logic [1:0]         status;

   modport source (output valid, popped_value, status, input ready);
   modport sink   (input valid, popped_value, status, output ready);
endinterface

// File: design/set_of_bounded_stacks.sv
`timescale 1ns / 1ps
// set_of_bounded_stacks: one stack built from fixed-capacity banks in an entry memory
// depends on sobs_pkg and the channel interfaces in sobs_if.sv

// One item is worked on at a time. A push or a rejected item goes from acceptance to
// its result through the accept and then the bank lookup with memory write, a push that
// opens a new substack takes a second lookup pass, and a pop or pop-at adds a read state,
// waiting on the registered read of the entry memory. The next item is taken as soon
// as the sequencer is idle, even while the previous result still sits in the output
// register. Bank fill counts and the position-to-bank map live in flops and are reset
// at once; the entry memory has no reset and needs no clearing pass, since a pop only
// reads entries below a bank's fill, which were always written before.
module set_of_bounded_stacks import sobs_pkg::*; #(
   parameter int SUB_CAPACITY  = 10,
   parameter int NUM_SUBSTACKS = 16,
   parameter int DATA_WIDTH    = 32
) (
   input  logic       clock,
   input  logic       reset,
   sobs_req_if.sink   req_ch,
   sobs_rsp_if.source rsp_ch
);

   localparam int BANK_W  = (NUM_SUBSTACKS > 1) ? $clog2(NUM_SUBSTACKS) : 1;
   localparam int LIVE_W  = $clog2(NUM_SUBSTACKS + 1);
   localparam int FILL_W  = $clog2(SUB_CAPACITY + 1);
   localparam int DEPTH   = NUM_SUBSTACKS * SUB_CAPACITY;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IDX_W   = (LIVE_W > POS_W) ? LIVE_W : POS_W;

   // sequencer and captured item
   state_type            state_ff, state_in;
   opcode_type           op_ff;
   logic [VALUE_W-1:0]   value_ff;
   logic [IDX_W-1:0]     pos_ff;
   logic [BANK_W-1:0]    bank_ff, bank_in;
   logic [IDX_W-1:0]     sel_ff, sel_in;

   // bank bookkeeping
   logic [LIVE_W-1:0]    live_ff, live_in;
   logic [FILL_W-1:0]    fill_ff [NUM_SUBSTACKS];
   logic [FILL_W-1:0]    fill_in [NUM_SUBSTACKS];
   logic [BANK_W-1:0]    map_ff  [NUM_SUBSTACKS];
   logic [BANK_W-1:0]    map_in  [NUM_SUBSTACKS];

   // entry memory
   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic                  mem_we, mem_re;
   logic [ADDR_W-1:0]     mem_addr;
   logic [ADDR_W-1:0]     bank_base;

   // result register
   logic                 rsp_valid_ff;
   logic [VALUE_W-1:0]   rsp_value_ff;
   status_type           rsp_status_ff;
   logic                 rsp_load;
   logic [VALUE_W-1:0]   res_value;
   status_type           res_status;

   logic                 req_accept;
   logic                 out_free;
   logic [IDX_W-1:0]     live_ext;
   logic [IDX_W-1:0]     top_pos;
   logic [IDX_W-1:0]     look_pos;
   logic [BANK_W-1:0]    look_bank;
   logic [FILL_W-1:0]    look_fill;
   logic                 need_new;
   logic                 pop_ok;
   logic [63:0]          rd_wide;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // bank lookup for the captured item
   assign live_ext  = IDX_W'(live_ff);
   assign top_pos   = live_ext - IDX_W'(1);
   assign look_pos  = (op_ff == OP_POP_AT) ? pos_ff : top_pos;
   assign look_bank = map_ff[look_pos[BANK_W-1:0]];
   assign look_fill = fill_ff[look_bank];
   assign bank_base = ADDR_W'(look_bank * SUB_CAPACITY);
   assign need_new  = (live_ff == '0) || (look_fill >= FILL_W'(SUB_CAPACITY));
   assign pop_ok    = (op_ff == OP_POP) ? (live_ff != '0) : (pos_ff < live_ext);
   assign rd_wide   = 64'(rd_data_ff);

   // next state, bookkeeping updates and result
   always_comb begin
      state_in   = state_ff;
      live_in    = live_ff;
      fill_in    = fill_ff;
      map_in     = map_ff;
      bank_in    = bank_ff;
      sel_in     = sel_ff;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_addr   = bank_base + ADDR_W'(look_fill);
      rsp_load   = 1'b0;
      res_value  = '0;
      res_status = ST_ERROR;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            if (out_free) begin
               case (op_ff)
                  OP_PUSH: begin
                     if (need_new) begin
                        if (live_ff >= LIVE_W'(NUM_SUBSTACKS)) begin
                           rsp_load   = 1'b1;
                           res_status = ST_FULL;
                           state_in   = S_IDLE;
                        end else begin
                           // banks past the live count are always empty
                           live_in = live_ff + LIVE_W'(1);
                        end
                     end else begin
                        mem_we             = 1'b1;
                        fill_in[look_bank] = look_fill + FILL_W'(1);
                        rsp_load           = 1'b1;
                        res_status         = ST_PUSHED;
                        state_in           = S_IDLE;
                     end
                  end
                  OP_POP, OP_POP_AT: begin
                     if (pop_ok) begin
                        mem_re             = 1'b1;
                        mem_addr           = bank_base + ADDR_W'(look_fill) - ADDR_W'(1);
                        fill_in[look_bank] = look_fill - FILL_W'(1);
                        bank_in            = look_bank;
                        sel_in             = look_pos;
                        state_in           = S_READ;
                     end else begin
                        rsp_load   = 1'b1;
                        res_status = ST_ERROR;
                        state_in   = S_IDLE;
                     end
                  end
                  default: begin
                     rsp_load   = 1'b1;
                     res_status = ST_ERROR;
                     state_in   = S_IDLE;
                  end
               endcase
            end
         end
         S_READ: begin
            if (out_free) begin
               rsp_load   = 1'b1;
               res_value  = rd_wide[VALUE_W-1:0];
               res_status = ST_POPPED;
               state_in   = S_IDLE;
               // drained bank: close the gap and park the bank after the live ones
               if (fill_ff[bank_ff] == '0) begin
                  live_in = live_ff - LIVE_W'(1);
                  for (int i = 0; i < NUM_SUBSTACKS - 1; i++) begin
                     if (IDX_W'(i) >= sel_ff && IDX_W'(i) < top_pos) begin
                        map_in[i] = map_ff[i+1];
                     end
                  end
                  for (int i = 0; i < NUM_SUBSTACKS; i++) begin
                     if (IDX_W'(i) == top_pos) begin
                        map_in[i] = bank_ff;
                     end
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         live_ff  <= '0;
         for (int i = 0; i < NUM_SUBSTACKS; i++) begin
            fill_ff[i] <= '0;
            map_ff[i]  <= BANK_W'(i);
         end
      end else begin
         state_ff <= state_in;
         live_ff  <= live_in;
         fill_ff  <= fill_in;
         map_ff   <= map_in;
      end
   end

   // captured item and pop bookkeeping
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff    <= opcode_type'(req_ch.opcode);
         value_ff <= req_ch.push_value;
         pos_ff   <= IDX_W'(req_ch.substack_position);
      end
      bank_ff <= bank_in;
      sel_ff  <= sel_in;
   end

   // entry memory, one port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= DATA_WIDTH'(value_ff);
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_value_ff  <= res_value;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.popped_value = rsp_value_ff;
   assign rsp_ch.status       = rsp_status_ff;

endmodule

// File: design/sobs_checker.sv
`timescale 1ns / 1ps
// sobs_props: port-level assertions on the result channel of set_of_bounded_stacks
// depends on sobs_pkg; bound to the top level at the end of this file

module sobs_props import sobs_pkg::*; #(
   parameter int SUB_CAPACITY  = 10,
   parameter int NUM_SUBSTACKS = 16
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_popped_value,
   input logic [1:0]  rsp_status
);

   localparam int CNT_W = $clog2(NUM_SUBSTACKS * SUB_CAPACITY + 1);

   logic [CNT_W-1:0] held_ff;
   logic             rsp_accept;

   assign rsp_accept = rsp_valid && rsp_ready;

   // entries held, from delivered results
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else if (rsp_accept && rsp_status == ST_PUSHED) begin
         held_ff <= held_ff + CNT_W'(1);
      end else if (rsp_accept && rsp_status == ST_POPPED) begin
         held_ff <= held_ff - CNT_W'(1);
      end
   end

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_popped_value) && $stable(rsp_status))
      else $error("result changed while stalled");

   // only a pop carries a value
   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_POPPED |-> rsp_popped_value == '0)
      else $error("non-pop result with nonzero value");

   // no pop from an empty stack
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_POPPED |-> held_ff != '0)
      else $error("pop reported with nothing held");

   // full needs every bank live with at least one entry
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> held_ff >= CNT_W'(NUM_SUBSTACKS))
      else $error("full reported with banks to spare");

endmodule

bind set_of_bounded_stacks sobs_props #(
   .SUB_CAPACITY  (SUB_CAPACITY),
   .NUM_SUBSTACKS (NUM_SUBSTACKS)
) u_sobs_props (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_popped_value (rsp_ch.popped_value),
   .rsp_status       (rsp_ch.status)
);

// File: verif/sobs_checker.sv
`timescale 1ns / 1ps
// sobs_checker: watches both item channels of the set of bounded stacks, predicts each result
// and compares it field by field with what the block returns
// depends on sobs_pkg and the channel interfaces in design/sobs_if.sv

module sobs_checker import sobs_pkg::*; #(
   parameter int SUB_CAPACITY  = 10,
   parameter int NUM_SUBSTACKS = 16,
   parameter int DATA_WIDTH    = 32
) (
   input  logic clock,
   input  logic reset,
   sobs_req_if  req_ch,
   sobs_rsp_if  rsp_ch,
   output int   mismatch_count,
   output int   results_due
);

   localparam int STORE_DEPTH = NUM_SUBSTACKS * SUB_CAPACITY;
   localparam int FILL_W      = $clog2(SUB_CAPACITY + 1);
   localparam int BANK_W      = (NUM_SUBSTACKS > 1) ? $clog2(NUM_SUBSTACKS) : 1;
   localparam int LIVE_W      = $clog2(NUM_SUBSTACKS + 1);
   localparam logic [63:0] DATA_MASK =
      (DATA_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << DATA_WIDTH) - 64'd1);

   typedef struct packed {
      logic [VALUE_W-1:0] popped_value;
      status_type         status;
   } stack_result_type;

   // results predicted for accepted items, oldest first
   stack_result_type stack_results_due [$];
   stack_result_type oldest_due;

   // predicted contents of the stack
   logic [VALUE_W-1:0] entry_mem [STORE_DEPTH];
   logic [FILL_W-1:0]  bank_fill [NUM_SUBSTACKS];
   logic [BANK_W-1:0]  bank_at_position [NUM_SUBSTACKS];
   logic [LIVE_W-1:0]  live_count;

   initial mismatch_count = 0;

   task automatic report_mismatch(string what);
      $display("[%0t] sobs_checker: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic void clear_stacks();
      for (int i = 0; i < NUM_SUBSTACKS; i++) begin
         bank_fill[i]        = '0;
         bank_at_position[i] = BANK_W'(i);
      end
      live_count = '0;
      stack_results_due.delete();
   endfunction

   // remove the top entry of a bank
   function automatic logic [VALUE_W-1:0] take_top(logic [BANK_W-1:0] bank);
      bank_fill[bank] = bank_fill[bank] - 1'b1;
      return entry_mem[int'(bank) * SUB_CAPACITY + int'(bank_fill[bank])];
   endfunction

   function automatic stack_result_type apply_stack_op(logic [1:0] op,
                                                       logic [VALUE_W-1:0] value,
                                                       logic [POS_W-1:0] pos);
      stack_result_type  res;
      logic [BANK_W-1:0] bank;
      logic              need_bank;
      int                i;
      res.popped_value = '0;
      res.status       = ST_ERROR;
      case (op)
         OP_PUSH: begin
            need_bank = (live_count == 0) ||
                        (bank_fill[bank_at_position[live_count - 1'b1]] >= SUB_CAPACITY);
            if (need_bank && live_count >= NUM_SUBSTACKS) begin
               res.status = ST_FULL;
            end else begin
               // a fresh substack takes the next bank in the map
               if (need_bank) begin
                  bank_fill[bank_at_position[live_count]] = '0;
                  live_count = live_count + 1'b1;
               end
               bank = bank_at_position[live_count - 1'b1];
               entry_mem[int'(bank) * SUB_CAPACITY + int'(bank_fill[bank])] =
                  value & DATA_MASK[VALUE_W-1:0];
               bank_fill[bank] = bank_fill[bank] + 1'b1;
               res.status = ST_PUSHED;
            end
         end
         OP_POP: begin
            if (live_count != 0) begin
               bank = bank_at_position[live_count - 1'b1];
               res.popped_value = take_top(bank);
               if (bank_fill[bank] == 0) begin
                  live_count = live_count - 1'b1;
               end
               res.status = ST_POPPED;
            end
         end
         OP_POP_AT: begin
            if (pos < live_count) begin
               bank = bank_at_position[pos];
               res.popped_value = take_top(bank);
               // an emptied substack moves to the end of the map, later ones shift down
               if (bank_fill[bank] == 0) begin
                  for (i = int'(pos); i + 1 < int'(live_count); i++) begin
                     bank_at_position[i] = bank_at_position[i + 1];
                  end
                  bank_at_position[live_count - 1'b1] = bank;
                  live_count = live_count - 1'b1;
               end
               res.status = ST_POPPED;
            end
         end
         default: begin
            res.status = ST_ERROR;
         end
      endcase
      return res;
   endfunction

   // results first: an item accepted at this edge cannot have its result yet
   always @(posedge clock) begin
      if (reset) begin
         clear_stacks();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (stack_results_due.size() == 0) begin
               report_mismatch($sformatf("result status %0d value %h with nothing expected",
                                         rsp_ch.status, rsp_ch.popped_value));
            end else begin
               oldest_due = stack_results_due.pop_front();
               if (rsp_ch.status !== oldest_due.status) begin
                  report_mismatch($sformatf("status %0d, expected %s", rsp_ch.status,
                                            oldest_due.status.name()));
               end
               if (rsp_ch.popped_value !== oldest_due.popped_value) begin
                  report_mismatch($sformatf("popped value %h, expected %h",
                                            rsp_ch.popped_value, oldest_due.popped_value));
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            stack_results_due = {stack_results_due,
                                 apply_stack_op(req_ch.opcode, req_ch.push_value,
                                                req_ch.substack_position)};
         end
      end
      results_due <= stack_results_due.size();
   end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// tb: drives push, pop, pop-at and unused-opcode items into the set of bounded stacks under random idling
// depends on sobs_pkg, design/sobs_if.sv, set_of_bounded_stacks and sobs_checker

module tb;
   import sobs_pkg::*;

   localparam int SUB_CAPACITY  = 10;
   localparam int NUM_SUBSTACKS = 16;
   localparam int DATA_WIDTH    = 32;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int LONG_HOLD      = 300;
   localparam int HOLD_AT_RESULT = 250;
   localparam int DRAIN_CYCLES   = 8;

   logic clock;
   logic reset;
   bit   sender_burst;
   int   mismatch_count;
   int   results_due;
   int   cycle_count;

   sobs_req_if req_ch ();
   sobs_rsp_if rsp_ch ();

   set_of_bounded_stacks #(
      .SUB_CAPACITY  (SUB_CAPACITY),
      .NUM_SUBSTACKS (NUM_SUBSTACKS),
      .DATA_WIDTH    (DATA_WIDTH)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   sobs_checker #(
      .SUB_CAPACITY  (SUB_CAPACITY),
      .NUM_SUBSTACKS (NUM_SUBSTACKS),
      .DATA_WIDTH    (DATA_WIDTH)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .mismatch_count (mismatch_count),
      .results_due    (results_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: errors");
      $finish;
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return ($urandom_range(0, 1) != 0) ? 32'h0000_0000 : 32'hffff_ffff;
         default: return $urandom();
      endcase
   endfunction

   // low positions are live far more often
   function automatic logic [3:0] pick_position();
      if ($urandom_range(0, 1) != 0) begin
         return 4'($urandom_range(0, 3));
      end
      return 4'($urandom_range(0, 15));
   endfunction

   // offer one item after a random gap and hold it until accepted
   task automatic offer_op(logic [1:0] op, logic [31:0] value, logic [3:0] pos);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.opcode            <= op;
      req_ch.push_value        <= value;
      req_ch.substack_position <= pos;
      req_ch.valid             <= 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic random_op(int push_pct, int pop_pct, int noise_pct);
      int         pick;
      logic [1:0] op;
      pick = $urandom_range(0, 99);
      if (pick < noise_pct) begin
         op = OP_UNUSED;
      end else if (pick < noise_pct + push_pct) begin
         op = OP_PUSH;
      end else if (pick < noise_pct + push_pct + pop_pct) begin
         op = OP_POP;
      end else begin
         op = OP_POP_AT;
      end
      offer_op(op, pick_value(), pick_position());
   endtask

   // stop offering until every predicted result has come back
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (results_due != 0) @(negedge clock);
   endtask

   // result side: random stall per item, quiet stretches, one long hold
   initial begin
      int stall;
      int taken;
      rsp_ch.ready = 1'b0;
      taken = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (taken == HOLD_AT_RESULT) begin
            stall = LONG_HOLD;
         end else if (((taken / 64) % 2) == 1) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, 4);
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         taken++;
         @(negedge clock);
      end
   end

   // stimulus and verdict
   initial begin
      int k;
      reset                    = 1'b1;
      req_ch.valid             = 1'b0;
      req_ch.opcode            = OP_PUSH;
      req_ch.push_value        = '0;
      req_ch.substack_position = '0;
      sender_burst             = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // errors on an empty stack and the unused opcode
      offer_op(OP_POP, 32'h0, 4'h0);
      offer_op(OP_POP_AT, 32'h0, 4'h0);
      offer_op(OP_UNUSED, 32'hffff_ffff, 4'hf);

      // value extremes into the first substack
      offer_op(OP_PUSH, 32'h7fff_ffff, 4'h0);
      offer_op(OP_PUSH, 32'h8000_0000, 4'h0);
      offer_op(OP_PUSH, 32'h0000_0000, 4'h0);
      offer_op(OP_PUSH, 32'hffff_ffff, 4'h0);
      offer_op(OP_PUSH, 32'ha5a5_a5a5, 4'h0);
      offer_op(OP_PUSH, 32'h5a5a_5a5a, 4'h0);

      // position at the live count and past it, then good pops
      offer_op(OP_POP_AT, 32'h0, 4'h1);
      offer_op(OP_POP_AT, 32'h0, 4'hf);
      offer_op(OP_POP_AT, 32'h0, 4'h0);
      offer_op(OP_POP, 32'h0, 4'h0);

      // fill the first substack and open a second
      for (k = 1; k <= 7; k++) begin
         offer_op(OP_PUSH, 32'h1111_1111 * k, 4'h0);
      end

      // pop-at past the live count, pop-at empties the last substack, then pops from the first
      offer_op(OP_POP_AT, 32'h0, 4'h2);
      offer_op(OP_POP_AT, 32'h0, 4'h1);
      offer_op(OP_POP_AT, 32'h0, 4'h0);
      offer_op(OP_POP, 32'h0, 4'h0);
      offer_op(OP_UNUSED, 32'h0, 4'h0);
      wait_drained();

      // mixed traffic
      repeat (150) random_op(50, 25, 3);
      wait_drained();

      // back-to-back pushes run into full while the result side holds off
      sender_burst = 1'b1;
      repeat (220) random_op(95, 3, 0);
      sender_burst = 1'b0;

      // drain through pops and pop-at, then a mix with noise
      repeat (200) random_op(10, 45, 2);
      repeat (130) random_op(40, 30, 5);
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
